### hdl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types, codes and helpers for the nucleotide pair counter.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int CountBits  = 32;
    localparam int ReportBits = 32;
    localparam int NumLetters = 4;
    localparam int NumPairs   = 16;
    localparam int NumCells   = NumLetters + NumPairs + 1;
    localparam int IdxBits    = $clog2(NumCells);
    localparam int PairBase   = NumLetters;
    localparam int LengthCell = NumLetters + NumPairs;

    localparam logic [1:0] ACT_TEXT  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_DUMP  = 2'd2;

    localparam logic [1:0] KIND_LETTER = 2'd0;
    localparam logic [1:0] KIND_PAIR   = 2'd1;
    localparam logic [1:0] KIND_LENGTH = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic       valid;
        logic [1:0] base;
    } t_base;

    function automatic t_base f_base_of(logic [7:0] sym);
        t_base r;
        r.valid = 1'b1;
        unique case (sym)
            8'h41, 8'h61: r.base = 2'd0;
            8'h43, 8'h63: r.base = 2'd1;
            8'h47, 8'h67: r.base = 2'd2;
            8'h54, 8'h74: r.base = 2'd3;
            default: begin
                r.valid = 1'b0;
                r.base  = 2'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [ReportBits-1:0] f_report(logic [CountBits-1:0] v);
        logic [CountBits+ReportBits-1:0] w;
        w = (CountBits + ReportBits)'(v);
        if (w > (CountBits + ReportBits)'({ReportBits{1'b1}})) begin
            return '1;
        end
        return w[ReportBits-1:0];
    endfunction

endpackage

### hdl/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell
// One saturating counter with a snapshot register that shifts to its neighbor.
// ----------------------------------------------------------------------------
module npc_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  npc_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_inc,
    input  logic [npc_pkg::ReportBits-1:0]    i_shift_in,
    output logic [npc_pkg::ReportBits-1:0]    o_shift_out
);
    import npc_pkg::*;

    logic [CountBits-1:0]  r_count, n_count;
    logic [ReportBits-1:0] r_snap, n_snap;

    always_comb begin
        n_count = r_count;
        if (i_ctl.clr) begin
            n_count = '0;
        end else if (i_inc && (r_count != {CountBits{1'b1}})) begin
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        n_snap = r_snap;
        if (i_ctl.load) begin
            n_snap = f_report(r_count);
        end else if (i_ctl.shift) begin
            n_snap = i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
    end

    assign o_shift_out = r_snap;

endmodule

### hdl/nucleotide_pair_counter_core.sv
// ----------------------------------------------------------------------------
// nucleotide_pair_counter_core
// Letter, pair and length counts over a DNA byte stream, held in a row of
// 21 counter cells whose snapshots shift out toward cell 0 on a dump.
// Text and clear requests: one per unstalled cycle, no result, registered update.
// Dump request: snapshot on accept, results from the next cycle, one per
// unstalled cycle (21 total); o_stall holds off every request until the
// last result is taken.
// Synchronous active-low reset zeroes all counts; no clearing pass.
// ----------------------------------------------------------------------------
module nucleotide_pair_counter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_symbol,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_first_base,
    output logic [1:0]  o_second_base,
    output logic [31:0] o_count,
    output logic        o_last
);
    import npc_pkg::*;

    logic               r_busy, n_busy;
    logic [IdxBits-1:0] r_idx, n_idx;
    logic [1:0]         r_prev_base, n_prev_base;
    logic               r_prev_valid, n_prev_valid;

    logic               in_acc, out_acc;
    t_base              cur;
    t_cell_ctl          ctl;
    logic [NumCells-1:0] inc;
    logic [ReportBits-1:0] chain [NumCells+1];
    logic [IdxBits-1:0] pair_idx;

    assign o_stall = r_busy;
    assign in_acc  = i_valid && !r_busy;
    assign out_acc = r_busy && !i_stall;
    assign cur     = f_base_of(i_symbol);

    always_comb begin
        ctl.clr   = in_acc && (i_action == ACT_CLEAR);
        ctl.load  = in_acc && (i_action == ACT_DUMP);
        ctl.shift = out_acc;
    end

    always_comb begin
        inc = '0;
        if (in_acc && (i_action == ACT_TEXT)) begin
            inc[LengthCell] = 1'b1;
            if (cur.valid) begin
                inc[cur.base] = 1'b1;
                if (r_prev_valid) begin
                    inc[PairBase + {r_prev_base, cur.base}] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_prev_base  = r_prev_base;
        n_prev_valid = r_prev_valid;
        if (ctl.clr) begin
            n_prev_base  = 2'd0;
            n_prev_valid = 1'b0;
        end else if (in_acc && (i_action == ACT_TEXT)) begin
            n_prev_valid = cur.valid;
            if (cur.valid) begin
                n_prev_base = cur.base;
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (ctl.load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (out_acc) begin
            if (r_idx == IdxBits'(LengthCell)) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_idx        <= '0;
            r_prev_base  <= 2'd0;
            r_prev_valid <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_idx        <= n_idx;
            r_prev_base  <= n_prev_base;
            r_prev_valid <= n_prev_valid;
        end
    end

    assign chain[NumCells] = '0;

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        npc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_inc       (inc[g]),
            .i_shift_in  (chain[g+1]),
            .o_shift_out (chain[g])
        );
    end

    assign pair_idx = r_idx - IdxBits'(PairBase);

    always_comb begin
        o_kind        = KIND_LENGTH;
        o_first_base  = 2'd0;
        o_second_base = 2'd0;
        if (r_idx < IdxBits'(PairBase)) begin
            o_kind       = KIND_LETTER;
            o_first_base = r_idx[1:0];
        end else if (r_idx < IdxBits'(LengthCell)) begin
            o_kind        = KIND_PAIR;
            o_first_base  = pair_idx[3:2];
            o_second_base = pair_idx[1:0];
        end
    end

    assign o_valid = r_busy;
    assign o_count = chain[0];
    assign o_last  = (r_idx == IdxBits'(LengthCell));

endmodule

### hdl/npc_checker.sv
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks for the nucleotide pair counter, bound to the top level.
// ----------------------------------------------------------------------------
module npc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_action,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [1:0]  o_first_base,
    input logic [1:0]  o_second_base,
    input logic [31:0] o_count,
    input logic        o_last
);
    import npc_pkg::*;

    a_dump_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == ACT_DUMP)
        |=> (o_valid && o_kind == KIND_LETTER && o_first_base == 2'd0))
        else $error("dump did not start with letter A");

    a_last_is_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_kind == KIND_LENGTH && o_second_base == 2'd0))
        else $error("last result is not the length");

    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> !o_valid)
        else $error("results continue after last");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_count) && $stable(o_kind)))
        else $error("stalled result changed");

endmodule

bind nucleotide_pair_counter_core npc_checker u_npc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_action      (i_action),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_kind        (o_kind),
    .o_first_base  (o_first_base),
    .o_second_base (o_second_base),
    .o_count       (o_count),
    .o_last        (o_last)
);
